/* rtl/sql_like_wildcard_matcher_unit_macros.svh */
// ----------------------------------------------------------------------------
// SQL LIKE matcher assertion macros
// Concurrent assertion wrappers shared by the matcher RTL; they expand to
// nothing when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef SQL_LIKE_WILDCARD_MATCHER_UNIT_MACROS_SVH
`define SQL_LIKE_WILDCARD_MATCHER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define SLWM_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define SLWM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SLWM_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define SLWM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

/* rtl/slwm_pkg.sv */
// ----------------------------------------------------------------------------
// SQL LIKE matcher package
// Beat formats, operation and element codes, and the control and chain
// structures shared by the matcher cells and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package slwm_pkg;

    localparam int CODE_W = 21;

    localparam logic [CODE_W-1:0] CHAR_UNDERSCORE = 21'h00005F;
    localparam logic [CODE_W-1:0] CHAR_PERCENT    = 21'h000025;
    localparam logic [CODE_W-1:0] CHAR_BACKSLASH  = 21'h00005C;
    localparam logic [CODE_W-1:0] CHAR_UPPER_A    = 21'h000041;
    localparam logic [CODE_W-1:0] CHAR_UPPER_Z    = 21'h00005A;
    localparam logic [CODE_W-1:0] CASE_OFFSET     = 21'h000020;

    typedef enum logic [1:0] {
        OP_CLEAR   = 2'd0,
        OP_APPEND  = 2'd1,
        OP_SUBJECT = 2'd2,
        OP_END     = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        KIND_LITERAL = 2'd0,
        KIND_ONE     = 2'd1,
        KIND_RUN     = 2'd2
    } kind_t;

    // How the cells form their next live bit.
    typedef enum logic [1:0] {
        MODE_HOLD    = 2'd0,
        MODE_STEP    = 2'd1,
        MODE_RESTART = 2'd2,
        MODE_KILL    = 2'd3
    } mode_t;

    typedef struct packed {
        logic [1:0]        operation;
        logic [CODE_W-1:0] char_code;
        logic              char_invalid;
    } item_t;

    typedef struct packed {
        logic matched;
        logic pattern_overflow;
    } result_t;

    // Broadcast from the top level to every cell.
    typedef struct packed {
        mode_t             mode;
        logic              we;
        kind_t             wr_kind;
        logic [CODE_W-1:0] wr_code;
        logic [CODE_W-1:0] subj;
        logic              fold_en;
    } ctl_t;

    // Handed from one cell to the next.
    typedef struct packed {
        logic adv;
        logic skip;
        logic sealed;
        logic at_end;
    } link_t;

    function automatic logic [CODE_W-1:0] fold_char(input logic [CODE_W-1:0] c,
                                                     input logic en);
        logic [CODE_W-1:0] r;
        r = c;
        if (en && c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z)
        begin
            r = c + CASE_OFFSET;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* rtl/slwm_cell.sv */
// ----------------------------------------------------------------------------
// SQL LIKE matcher cell
// Holds one pattern element and the live bit of the NFA position in front of
// it; advances and closes the live set together with its neighbors.
// ----------------------------------------------------------------------------
`default_nettype none

module slwm_cell #(
    parameter int PATTERN_MAX = 32,
    parameter int IDX         = 0
) (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  wire slwm_pkg::ctl_t                  ctl,
    input  wire [$clog2(PATTERN_MAX+1)-1:0]      count,
    input  wire slwm_pkg::link_t                 chain_in,
    output slwm_pkg::link_t                      chain_out
);

    localparam int CNT_W = $clog2(PATTERN_MAX + 1);
    localparam logic [CNT_W-1:0] IDX_C  = CNT_W'(IDX);
    localparam logic [CNT_W-1:0] IDX_P1 = CNT_W'(IDX + 1);

    slwm_pkg::kind_t                 kind_reg;
    logic [slwm_pkg::CODE_W-1:0]     code_reg;
    logic                            live_reg;
    logic                            live_next;

    logic                            hit;
    slwm_pkg::kind_t                 kind_eff;
    logic [slwm_pkg::CODE_W-1:0]     code_eff;
    logic                            active;
    logic                            is_run;
    logic                            consumes;
    logic                            self_keep;
    logic                            adv_out;
    logic                            closed;

    // The element being written in this cycle is already in effect.
    assign hit      = ctl.we && (count == IDX_P1);
    assign kind_eff = hit ? ctl.wr_kind : kind_reg;
    assign code_eff = hit ? ctl.wr_code : code_reg;
    assign active   = (count > IDX_C);

    always_comb
    begin
        is_run   = 1'b0;
        consumes = 1'b0;
        case (kind_eff)
            slwm_pkg::KIND_RUN:
            begin
                is_run = active;
            end
            slwm_pkg::KIND_ONE:
            begin
                consumes = active;
            end
            slwm_pkg::KIND_LITERAL:
            begin
                consumes = active &&
                    (slwm_pkg::fold_char(code_eff, ctl.fold_en) == ctl.subj);
            end
            default:
            begin
                consumes = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        self_keep = 1'b0;
        adv_out   = 1'b0;
        case (ctl.mode)
            slwm_pkg::MODE_HOLD:
            begin
                self_keep = live_reg;
            end
            slwm_pkg::MODE_STEP:
            begin
                self_keep = live_reg && is_run;
                adv_out   = live_reg && consumes;
            end
            default:
            begin
                self_keep = 1'b0;
            end
        endcase
    end

    // A live position in front of a run also makes the next one live.
    assign closed    = self_keep || chain_in.adv || chain_in.skip;
    assign live_next = closed;

    assign chain_out.adv    = adv_out;
    assign chain_out.skip   = closed && is_run;
    assign chain_out.sealed = chain_in.sealed || (live_reg && is_run && count == IDX_P1);
    assign chain_out.at_end = chain_in.at_end || (live_reg && count == IDX_C);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            live_reg <= (IDX == 0);
        end
        else
        begin
            live_reg <= live_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (hit)
        begin
            kind_reg <= ctl.wr_kind;
            code_reg <= ctl.wr_code;
        end
    end

endmodule

`default_nettype wire

/* rtl/slwm_out_buf.sv */
// ----------------------------------------------------------------------------
// SQL LIKE matcher result buffer
// Output register with a skid entry, so the input side keeps moving while a
// result beat waits on the receiver.
// ----------------------------------------------------------------------------
`default_nettype none
`include "sql_like_wildcard_matcher_unit_macros.svh"

module slwm_out_buf (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    push,
    input  wire slwm_pkg::result_t push_data,
    output logic                   full,
    output logic                   valid,
    input  wire                    stall,
    output slwm_pkg::result_t      data
);

    logic              main_valid_reg;
    logic              main_valid_next;
    slwm_pkg::result_t main_data_reg;
    slwm_pkg::result_t main_data_next;
    logic              skid_valid_reg;
    logic              skid_valid_next;
    slwm_pkg::result_t skid_data_reg;
    slwm_pkg::result_t skid_data_next;
    logic              pop;

    assign pop   = main_valid_reg && !stall;
    assign full  = skid_valid_reg;
    assign valid = main_valid_reg;
    assign data  = main_data_reg;

    always_comb
    begin
        main_valid_next = main_valid_reg;
        main_data_next  = main_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (pop)
        begin
            main_valid_next = skid_valid_reg;
            main_data_next  = skid_data_reg;
            skid_valid_next = 1'b0;
        end
        if (push)
        begin
            if (!main_valid_next)
            begin
                main_valid_next = 1'b1;
                main_data_next  = push_data;
            end
            else
            begin
                skid_valid_next = 1'b1;
                skid_data_next  = push_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_data_reg <= main_data_next;
        skid_data_reg <= skid_data_next;
    end

    `SLWM_ASSERT_IMP(a_skid_behind_main, clk, rst_n, skid_valid_reg, main_valid_reg, "skid entry without output entry")
    `SLWM_ASSERT_IMP(a_no_push_when_full, clk, rst_n, push, !skid_valid_reg, "result pushed into a full buffer")
    `SLWM_ASSERT_NEXT(a_skid_moves_up, clk, rst_n, main_valid_reg && skid_valid_reg && !stall, main_valid_reg, "skid entry lost on pop")

endmodule

`default_nettype wire

/* rtl/sql_like_wildcard_matcher_unit.sv */
// ----------------------------------------------------------------------------
// SQL LIKE wildcard matcher
// Whole-string LIKE match over code points with a row of NFA cells, one per
// pattern element.
// ----------------------------------------------------------------------------
// Usage: items arrive on the item channel (item_valid, item_stall, item). An
// operation clears the pattern, appends a pattern character, feeds a subject
// character or ends the subject. Only the end of a subject produces a result
// beat on the result channel (result_valid, result_stall, result), carrying
// matched and pattern_overflow. The ignore_case register is written through
// cfg_valid, cfg_ready and cfg_data; cfg_ready is always high.
// Throughput is one item per cycle for every operation while item_stall is low.
// A result beat is registered in the output register, or in the skid entry. The
// clock period is set by the skip propagation of percent elements along the row
// of cells, which ripples combinationally through all PATTERN_MAX cells.
// Reset empties the pattern, leaves only position zero live and clears the
// result buffer; no clearing pass is needed. A stalled receiver fills the
// output register and then a skid entry; item_stall rises only when both hold
// a result.
// ----------------------------------------------------------------------------
`default_nettype none
`include "sql_like_wildcard_matcher_unit_macros.svh"

module sql_like_wildcard_matcher_unit #(
    parameter int PATTERN_MAX = 32
) (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    item_valid,
    output logic                   item_stall,
    input  wire slwm_pkg::item_t   item,
    output logic                   result_valid,
    input  wire                    result_stall,
    output slwm_pkg::result_t      result,
    input  wire                    cfg_valid,
    output logic                   cfg_ready,
    input  wire                    cfg_data
);

    localparam int CNT_W = $clog2(PATTERN_MAX + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(PATTERN_MAX);

    logic                            ignore_case_reg;
    logic [CNT_W-1:0]                count_reg;
    logic [CNT_W-1:0]                count_next;
    logic                            esc_reg;
    logic                            esc_next;
    logic                            ovf_reg;
    logic                            ovf_next;
    logic                            sealed_reg;
    logic                            sealed_next;
    logic                            live_top_reg;

    logic                            accept;
    logic                            write_req;
    slwm_pkg::kind_t                 write_kind;
    logic [slwm_pkg::CODE_W-1:0]     write_code;
    slwm_pkg::ctl_t                  ctl;
    slwm_pkg::link_t                 chain [PATTERN_MAX+1];
    logic                            at_end_any;
    logic                            push;
    slwm_pkg::result_t               push_data;

    assign accept    = item_valid && !item_stall;
    assign cfg_ready = 1'b1;

    // Pattern building and the mode that the cells take for this item.
    always_comb
    begin
        write_req   = 1'b0;
        write_kind  = slwm_pkg::KIND_LITERAL;
        write_code  = item.char_code;
        esc_next    = esc_reg;
        count_next  = count_reg;
        ovf_next    = ovf_reg;
        sealed_next = sealed_reg;
        ctl.mode    = slwm_pkg::MODE_HOLD;
        if (accept)
        begin
            case (slwm_pkg::op_t'(item.operation))
                slwm_pkg::OP_CLEAR:
                begin
                    ctl.mode    = slwm_pkg::MODE_RESTART;
                    esc_next    = 1'b0;
                    count_next  = '0;
                    ovf_next    = 1'b0;
                    sealed_next = 1'b0;
                end
                slwm_pkg::OP_APPEND:
                begin
                    if (esc_reg)
                    begin
                        esc_next  = 1'b0;
                        write_req = 1'b1;
                    end
                    else if (item.char_code == slwm_pkg::CHAR_BACKSLASH)
                    begin
                        esc_next = 1'b1;
                    end
                    else if (item.char_code == slwm_pkg::CHAR_UNDERSCORE)
                    begin
                        write_req  = 1'b1;
                        write_kind = slwm_pkg::KIND_ONE;
                    end
                    else if (item.char_code == slwm_pkg::CHAR_PERCENT)
                    begin
                        write_req  = 1'b1;
                        write_kind = slwm_pkg::KIND_RUN;
                    end
                    else
                    begin
                        write_req = 1'b1;
                    end
                end
                slwm_pkg::OP_SUBJECT:
                begin
                    ctl.mode    = item.char_invalid ? slwm_pkg::MODE_KILL
                                                    : slwm_pkg::MODE_STEP;
                    sealed_next = sealed_reg || chain[PATTERN_MAX].sealed;
                end
                slwm_pkg::OP_END:
                begin
                    ctl.mode    = slwm_pkg::MODE_RESTART;
                    sealed_next = 1'b0;
                end
                default:
                begin
                    ctl.mode = slwm_pkg::MODE_HOLD;
                end
            endcase
            // A trailing backslash becomes a literal once the subject starts.
            if ((item.operation == slwm_pkg::OP_SUBJECT ||
                 item.operation == slwm_pkg::OP_END) && esc_reg)
            begin
                esc_next   = 1'b0;
                write_req  = 1'b1;
                write_code = slwm_pkg::CHAR_BACKSLASH;
            end
        end
        ctl.we = 1'b0;
        if (write_req)
        begin
            if (count_reg < CNT_MAX)
            begin
                ctl.we     = 1'b1;
                count_next = count_reg + CNT_W'(1);
            end
            else
            begin
                ovf_next = 1'b1;
            end
        end
        ctl.wr_kind = write_kind;
        ctl.wr_code = write_code;
        ctl.subj    = slwm_pkg::fold_char(item.char_code, ignore_case_reg);
        ctl.fold_en = ignore_case_reg;
    end

    // Restart seeds position zero; the cells close it over leading runs.
    assign chain[0].adv    = (ctl.mode == slwm_pkg::MODE_RESTART);
    assign chain[0].skip   = 1'b0;
    assign chain[0].sealed = 1'b0;
    assign chain[0].at_end = 1'b0;

    for (genvar g = 0; g < PATTERN_MAX; g++)
    begin : g_cell
        slwm_cell #(
            .PATTERN_MAX (PATTERN_MAX),
            .IDX         (g)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl       (ctl),
            .count     (count_next),
            .chain_in  (chain[g]),
            .chain_out (chain[g+1])
        );
    end

    assign at_end_any = chain[PATTERN_MAX].at_end ||
                        (live_top_reg && count_next == CNT_MAX);

    assign push = accept && (item.operation == slwm_pkg::OP_END);
    assign push_data.matched          = !ovf_next && (sealed_reg || at_end_any);
    assign push_data.pattern_overflow = ovf_next;

    slwm_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (item_stall),
        .valid     (result_valid),
        .stall     (result_stall),
        .data      (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ignore_case_reg <= 1'b0;
            count_reg       <= '0;
            esc_reg         <= 1'b0;
            ovf_reg         <= 1'b0;
            sealed_reg      <= 1'b0;
            live_top_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                ignore_case_reg <= cfg_data;
            end
            count_reg    <= count_next;
            esc_reg      <= esc_next;
            ovf_reg      <= ovf_next;
            sealed_reg   <= sealed_next;
            // The end position has no cell of its own, so it keeps itself on hold.
            live_top_reg <= chain[PATTERN_MAX].adv || chain[PATTERN_MAX].skip ||
                            (ctl.mode == slwm_pkg::MODE_HOLD && live_top_reg);
        end
    end

    `SLWM_ASSERT_IMP(a_count_range, clk, rst_n, 1'b1, count_reg <= CNT_MAX, "element count beyond store")
    `SLWM_ASSERT_IMP(a_ovf_full, clk, rst_n, ovf_reg, count_reg == CNT_MAX, "overflow with room left in store")
    `SLWM_ASSERT_NEXT(a_clear_empties, clk, rst_n, accept && item.operation == slwm_pkg::OP_CLEAR, count_reg == '0 && !ovf_reg && !esc_reg && !sealed_reg, "clear left pattern state behind")

endmodule

`default_nettype wire
